>>> sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication form, antecedent then consequent
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/lbhp_pkg.sv
// types and constants of the two-cluster core hotplug policy
`default_nettype none
package lbhp_pkg;
  localparam int FREQ_W     = 22;
  localparam int PCT_W      = 7;
  localparam int MIN_W      = 3;
  localparam int WAIT_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int TICK_W     = 16;

  localparam logic [1:0] OP_TICK       = 2'd0;
  localparam logic [1:0] OP_SCREEN_OFF = 2'd1;
  localparam logic [1:0] OP_SCREEN_ON  = 2'd2;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_ONLINE  = 2'd1;
  localparam logic [1:0] ACT_OFFLINE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LITTLE_UP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LITTLE_DOWN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_UP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_DOWN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LITTLE_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_MIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UP_WAIT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_WAIT   = 3'd7;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [FREQ_W-1:0] freq_core0;
    logic [FREQ_W-1:0] freq_core1;
    logic [FREQ_W-1:0] freq_core2;
    logic [FREQ_W-1:0] freq_core3;
    logic [FREQ_W-1:0] freq_core4;
    logic [FREQ_W-1:0] freq_core5;
    logic [FREQ_W-1:0] freq_core6;
    logic [FREQ_W-1:0] freq_core7;
    logic [FREQ_W-1:0] little_max_freq;
    logic [FREQ_W-1:0] big_max_freq;
  } in_t;

  typedef struct packed {
    logic [2:0] core_index;
    logic [1:0] action;
    logic       last_command;
    logic [7:0] online_mask;
  } out_t;

  typedef enum logic [1:0] {K_NONE, K_TICK, K_OFF, K_ON} kind_t;

  typedef struct packed {
    kind_t kind;
    in_t   item;
  } q_item_t;

  typedef struct packed {
    logic we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_LDEC, ST_XBIG, ST_XSHED, ST_BDEC, ST_SWEEP, ST_FLUSH
  } state_t;
endpackage
`default_nettype wire

>>> sv/load_based_core_hotplug_policy.sv
// top level of the two-cluster core hotplug policy
// usage:
// - input channel in_valid/in_stall/in_item: one item per governor event
//   (load tick, screen off, screen on), taken when in_valid is high and
//   in_stall is low; a two-item queue sits behind it
// - output channel out_valid/out_stall/out_item: a run of one to seven
//   commands per item, the last one flagged by last_command; an item that
//   changes nothing yields a single no-change command
// - config port cfg_we/cfg_index/cfg_data writes the eight threshold and
//   wait registers; write only while the block is idle
// - sequencing: the back end sequencer passes an idle state per item, then
//   takes one step per cycle while the output does not stall, with at most
//   one command per step; a tick steps through load, little decision, big
//   check, then the big decision or a big bring-up with littles shed, then
//   flush; screen off/on steps through load, sweep steps that move one core
//   each, then flush; commands pass a holding register to the output
// - rst (synchronous) puts all cores online, clears the tick counter,
//   loads the default registers and empties queue and output
// - when the receiver stalls the output register holds; the sequencer
//   waits while the queue keeps taking items until it is full
`default_nettype none
module load_based_core_hotplug_policy #(
  parameter int CORES_PER_CLUSTER = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lbhp_pkg::in_t                    in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lbhp_pkg::out_t                   out_item,
  input  logic                             cfg_we,
  input  logic [lbhp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbhp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lbhp_pkg::*;

  // queue between front and back
  logic    q_valid, q_pop;
  q_item_t q_data;
  cfg_wr_t cfg;

  assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

  // front: take items, classify opcode
  lbhp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  // back: policy sequencer and output register
  lbhp_back #(
    .CORES_PER_CLUSTER (CORES_PER_CLUSTER)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );
endmodule
`default_nettype wire

>>> sv/lbhp_front.sv
// front end: accepts items, classifies the opcode, two-entry queue
`default_nettype none
module lbhp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  lbhp_pkg::in_t   in_item,
  output logic            q_valid,
  input  logic            q_pop,
  output lbhp_pkg::q_item_t q_data
);
  import lbhp_pkg::*;

  q_item_t    entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;
  kind_t      kind;

  always_comb begin
    case (in_item.opcode)
      OP_TICK:       kind = K_TICK;
      OP_SCREEN_OFF: kind = K_OFF;
      OP_SCREEN_ON:  kind = K_ON;
      default:       kind = K_NONE;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{kind: kind, item: in_item};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

>>> sv/lbhp_back.sv
// back end: config registers, core state and command sequencer
`default_nettype none
module lbhp_back #(
  parameter int CORES_PER_CLUSTER = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  lbhp_pkg::cfg_wr_t cfg,
  input  logic              q_valid,
  output logic              q_pop,
  input  lbhp_pkg::q_item_t q_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lbhp_pkg::out_t    out_item
);
  import lbhp_pkg::*;

  localparam int NCORES = (2 * CORES_PER_CLUSTER > 8) ? 8 : 2 * CORES_PER_CLUSTER;
  localparam int PROD_W = FREQ_W + PCT_W;
  localparam int CMP_W  = PROD_W + 1;
  localparam logic [7:0] ALL_ON = 8'((9'd1 << NCORES) - 9'd1);

  typedef struct packed {
    logic [FREQ_W-1:0] slow;
    logic [FREQ_W-1:0] fast;
    logic [3:0]        sc;
  } scan_t;

  typedef struct packed {
    logic       found;
    logic [3:0] idx;
  } find_t;

  // lowest set bit of mask within [lo, hi)
  function automatic find_t find_low(input logic [7:0] mask, input int lo, input int hi);
    find_t r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (i >= lo && i < hi && mask[i]) begin
        r.found = 1'b1;
        r.idx   = 4'(i);
      end
    end
    return r;
  endfunction

  // highest set bit of mask within [lo, hi)
  function automatic find_t find_high(input logic [7:0] mask, input int lo, input int hi);
    find_t r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (i >= lo && i < hi && mask[i]) begin
        r.found = 1'b1;
        r.idx   = 4'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [3:0] count_on(input logic [7:0] mask, input int lo, input int hi);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (i >= lo && i < hi && mask[i]) n = n + 4'd1;
    end
    return n;
  endfunction

  // slow/fast scan over the online cores of one cluster
  function automatic scan_t scan(input logic [7:0] mask, input logic [7:0][FREQ_W-1:0] fr,
                                 input int lo, input int hi, input logic [FREQ_W-1:0] first,
                                 input logic [3:0] sc0);
    scan_t r;
    logic  sv;
    r.slow = '0;
    r.fast = first;
    r.sc   = sc0;
    sv     = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i >= lo && i < hi && mask[i]) begin
        if (!sv || fr[i] <= r.slow) begin
          r.sc   = 4'(i);
          r.slow = fr[i];
          sv     = 1'b1;
        end else if (fr[i] > r.fast) begin
          r.fast = fr[i];
        end
      end
    end
    if (!sv || first < r.slow) r.slow = first;
    return r;
  endfunction

  // config registers
  logic [PCT_W-1:0]  little_up, little_down, big_up, big_down;
  logic [MIN_W-1:0]  little_min, big_min;
  logic [WAIT_W-1:0] up_wait, down_wait;

  state_t state, state_next;
  kind_t  kind;
  in_t    cur;
  logic [7:0]        online, online_next;
  logic [TICK_W-1:0] ticks, ticks_next;
  logic [PROD_W-1:0] p_lup, p_ldn, p_bup, p_bdn;

  logic       held_v;
  logic [2:0] held_core;
  logic [1:0] held_act;
  logic [7:0] held_mask;

  logic       adv, go;
  logic       cmd_v;
  logic [2:0] cmd_core;
  logic [1:0] cmd_act;

  logic [7:0][FREQ_W-1:0] fr;
  scan_t      sl, sb;
  find_t      f_any_off, f_big_off, f_little_on, f_big_on, f_top_on, f_low_off;
  logic [3:0] nl, nb;
  logic [FREQ_W-1:0] big_first;
  logic       uw_ok, dw_ok, dw3_ok;
  logic       l_up, l_dn, b_up, b_dn;

  assign fr[0] = cur.freq_core0;
  assign fr[1] = cur.freq_core1;
  assign fr[2] = cur.freq_core2;
  assign fr[3] = cur.freq_core3;
  assign fr[4] = cur.freq_core4;
  assign fr[5] = cur.freq_core5;
  assign fr[6] = cur.freq_core6;
  assign fr[7] = cur.freq_core7;

  assign adv   = !out_valid || !out_stall;
  assign go    = adv && (state != ST_IDLE);
  assign q_pop = (state == ST_IDLE);

  always_comb begin
    nl          = count_on(online, 0, CORES_PER_CLUSTER);
    nb          = count_on(online, CORES_PER_CLUSTER, NCORES);
    f_any_off   = find_low(~online, 1, NCORES);
    f_big_off   = find_low(~online, CORES_PER_CLUSTER, NCORES);
    f_little_on = find_low(online, 1, CORES_PER_CLUSTER);
    f_big_on    = find_low(online, CORES_PER_CLUSTER, NCORES);
    f_top_on    = find_high(online, 1, NCORES);
    f_low_off   = find_low(~online, 0, NCORES);
    big_first   = fr[f_big_on.idx[2:0]];
    sl = scan(online, fr, 1, CORES_PER_CLUSTER, fr[0], 4'd0);
    sb = scan(online, fr, CORES_PER_CLUSTER, NCORES, big_first, 4'(CORES_PER_CLUSTER));
    uw_ok  = ticks >= TICK_W'(up_wait);
    dw_ok  = ticks >= TICK_W'(down_wait);
    dw3_ok = ticks >= TICK_W'(10'(down_wait) * 10'd3);
    // level compares: s > floor(p/100) iff 100*s > p
    l_up = CMP_W'(sl.slow) * CMP_W'(100) > CMP_W'(p_lup);
    l_dn = (CMP_W'(sl.fast) + CMP_W'(1)) * CMP_W'(100) <= CMP_W'(p_ldn);
    b_up = CMP_W'(sb.slow) * CMP_W'(100) > CMP_W'(p_bup);
    b_dn = (CMP_W'(sb.fast) + CMP_W'(1)) * CMP_W'(100) <= CMP_W'(p_bdn);
  end

  always_comb begin
    state_next = state;
    ticks_next = ticks;
    cmd_v      = 1'b0;
    cmd_core   = '0;
    cmd_act    = ACT_NONE;
    case (state)
      ST_IDLE: begin
        if (q_valid) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        case (kind)
          K_TICK: begin
            state_next = ST_LDEC;
            if (ticks != {TICK_W{1'b1}}) ticks_next = ticks + TICK_W'(1);
          end
          K_OFF, K_ON: state_next = ST_SWEEP;
          default:     state_next = ST_FLUSH;
        endcase
      end
      ST_LDEC: begin
        state_next = ST_XBIG;
        if (l_up) begin
          if (nl < 4'(CORES_PER_CLUSTER) && uw_ok) begin
            ticks_next = '0;
            if (f_any_off.found) begin
              cmd_v    = 1'b1;
              cmd_core = f_any_off.idx[2:0];
              cmd_act  = ACT_ONLINE;
            end
          end
        end else if (sl.sc != 4'd0 && l_dn) begin
          if (nl > 4'(little_min) && dw_ok) begin
            ticks_next = '0;
            if (online[sl.sc[2:0]]) begin
              cmd_v    = 1'b1;
              cmd_core = sl.sc[2:0];
              cmd_act  = ACT_OFFLINE;
            end
          end
        end
      end
      ST_XBIG: begin
        if (nb != 4'd0) begin
          state_next = ST_BDEC;
        end else if (nl >= 4'(CORES_PER_CLUSTER)) begin
          state_next = ST_XSHED;
          if (f_big_off.found) begin
            cmd_v    = 1'b1;
            cmd_core = f_big_off.idx[2:0];
            cmd_act  = ACT_ONLINE;
          end
        end else begin
          state_next = ST_FLUSH;
        end
      end
      ST_XSHED: begin
        // shed the lowest littles until two remain
        if (nl > 4'd2 && f_little_on.found) begin
          cmd_v    = 1'b1;
          cmd_core = f_little_on.idx[2:0];
          cmd_act  = ACT_OFFLINE;
        end else begin
          state_next = ST_FLUSH;
        end
      end
      ST_BDEC: begin
        state_next = ST_FLUSH;
        if (b_up) begin
          if (nb < 4'(CORES_PER_CLUSTER) && uw_ok) begin
            ticks_next = '0;
            if (f_big_off.found) begin
              cmd_v    = 1'b1;
              cmd_core = f_big_off.idx[2:0];
              cmd_act  = ACT_ONLINE;
            end
          end
        end else if (b_dn) begin
          if (nb > 4'(big_min) && dw3_ok) begin
            ticks_next = '0;
            if (sb.sc < 4'(NCORES) && online[sb.sc[2:0]]) begin
              cmd_v    = 1'b1;
              cmd_core = sb.sc[2:0];
              cmd_act  = ACT_OFFLINE;
            end
          end
        end
      end
      ST_SWEEP: begin
        if (kind == K_OFF && f_top_on.found) begin
          cmd_v    = 1'b1;
          cmd_core = f_top_on.idx[2:0];
          cmd_act  = ACT_OFFLINE;
        end else if (kind == K_ON && f_low_off.found) begin
          cmd_v    = 1'b1;
          cmd_core = f_low_off.idx[2:0];
          cmd_act  = ACT_ONLINE;
        end else begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
    online_next = online;
    if (cmd_v && cmd_act == ACT_ONLINE) online_next[cmd_core] = 1'b1;
    if (cmd_v && cmd_act == ACT_OFFLINE) online_next[cmd_core] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      cur  <= q_data.item;
      kind <= q_data.kind;
    end
    if (go && state == ST_LOAD) begin
      p_lup <= PROD_W'(little_up) * PROD_W'(cur.little_max_freq);
      p_ldn <= PROD_W'(little_down) * PROD_W'(cur.little_max_freq);
      p_bup <= PROD_W'(big_up) * PROD_W'(cur.big_max_freq);
      p_bdn <= PROD_W'(big_down) * PROD_W'(cur.big_max_freq);
    end
    if (go && cmd_v) begin
      held_core <= cmd_core;
      held_act  <= cmd_act;
      held_mask <= online_next;
    end
    if (go && ((cmd_v && held_v) || state == ST_FLUSH)) begin
      out_item.core_index   <= (state == ST_FLUSH && !held_v) ? 3'd0 : held_core;
      out_item.action       <= (state == ST_FLUSH && !held_v) ? ACT_NONE : held_act;
      out_item.online_mask  <= (state == ST_FLUSH && !held_v) ? online : held_mask;
      out_item.last_command <= (state == ST_FLUSH);
    end
    if (rst) begin
      state       <= ST_IDLE;
      online      <= ALL_ON;
      ticks       <= '0;
      held_v      <= 1'b0;
      out_valid   <= 1'b0;
      little_up   <= PCT_W'(60);
      little_down <= PCT_W'(30);
      big_up      <= PCT_W'(90);
      big_down    <= PCT_W'(60);
      little_min  <= MIN_W'(1);
      big_min     <= MIN_W'(0);
      up_wait     <= WAIT_W'(1);
      down_wait   <= WAIT_W'(1);
    end else begin
      if (cfg.we) begin
        case (cfg.index)
          REG_LITTLE_UP:   little_up   <= cfg.data[PCT_W-1:0];
          REG_LITTLE_DOWN: little_down <= cfg.data[PCT_W-1:0];
          REG_BIG_UP:      big_up      <= cfg.data[PCT_W-1:0];
          REG_BIG_DOWN:    big_down    <= cfg.data[PCT_W-1:0];
          REG_LITTLE_MIN:  little_min  <= cfg.data[MIN_W-1:0];
          REG_BIG_MIN:     big_min     <= cfg.data[MIN_W-1:0];
          REG_UP_WAIT:     up_wait     <= cfg.data[WAIT_W-1:0];
          REG_DOWN_WAIT:   down_wait   <= cfg.data[WAIT_W-1:0];
          default: ;
        endcase
      end
      // output register loads a new command or empties once taken
      if (go && ((cmd_v && held_v) || state == ST_FLUSH)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_IDLE) begin
        state <= state_next;
      end else if (go) begin
        state  <= state_next;
        online <= online_next;
        ticks  <= ticks_next;
        if (cmd_v) held_v <= 1'b1;
        if (state == ST_FLUSH) held_v <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/lbhp_checker.sv
// port checker for the core hotplug policy, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module lbhp_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_stall,
  input lbhp_pkg::out_t out_item
);
  import lbhp_pkg::*;

  `CHK_IMPLY(a_out_hold, out_valid && out_stall, out_valid, "output item dropped under stall")
  `CHK_IMPLY(a_out_stable, out_valid && out_stall, $stable(out_item), "stalled output changed")
  `CHK_ASSERT(a_core0_on, !out_valid || out_item.online_mask[0], "core 0 reported offline")
  `CHK_ASSERT(a_act_legal, !out_valid || out_item.action != 2'd3, "illegal action code")
  `CHK_ASSERT(a_none_last, !out_valid || out_item.action != ACT_NONE || out_item.last_command, "no-change command not last")
endmodule

bind load_based_core_hotplug_policy lbhp_checker u_lbhp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire

>>> sim/load_based_core_hotplug_policy_tb.sv
// testbench for the two-cluster core hotplug policy: predictor, driver, monitor
`timescale 1ns / 100ps
`default_nettype none
module load_based_core_hotplug_policy_tb;
  import lbhp_pkg::*;

  localparam int NCL = 4;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t in_item;
  logic out_valid;
  logic out_stall;
  out_t out_item;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  load_based_core_hotplug_policy dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state, mirrors the block's registers
  logic [7:0] core_mask;
  logic [15:0] tick_count;
  logic [7:0] thresh [8];

  in_t pending_items [$];
  out_t expected_cmds [$];
  int error_count;
  int idle_cycles;
  bit quiet_phase;
  bit done;
  int in_gap;
  int out_hold;
  logic in_stall_seen;

  task automatic report(input string what);
    begin
      $display("mismatch: %s", what);
      error_count++;
    end
  endtask

  function automatic logic [21:0] core_freq(input in_t it, input int c);
    case (c)
      0: return it.freq_core0;
      1: return it.freq_core1;
      2: return it.freq_core2;
      3: return it.freq_core3;
      4: return it.freq_core4;
      5: return it.freq_core5;
      6: return it.freq_core6;
      default: return it.freq_core7;
    endcase
  endfunction

  function automatic int online_count(input int lo, input int hi);
    int n;
    n = 0;
    for (int c = lo; c < hi; c++) if (core_mask[c]) n++;
    return n;
  endfunction

  task automatic push_command(input int core, input logic [1:0] act, inout int n);
    out_t o;
    begin
      if (n < 7) begin
        if (act == ACT_ONLINE) core_mask[core] = 1'b1;
        else if (act == ACT_OFFLINE) core_mask[core] = 1'b0;
        o.core_index = core[2:0];
        o.action = act;
        o.last_command = 1'b0;
        o.online_mask = core_mask;
        expected_cmds.push_back(o);
        n++;
      end
    end
  endtask

  // governor tick: little cluster decision, big bring-up, big decision
  task automatic predict_tick(input in_t it, inout int n);
    longint lmax, bmax, up_l, dn_l, up_b, dn_b, r, fast, slow, first;
    int sc, nl, nb, b0, c;
    begin
      lmax = it.little_max_freq;
      bmax = it.big_max_freq;
      up_l = thresh[REG_LITTLE_UP] * lmax / 100;
      dn_l = thresh[REG_LITTLE_DOWN] * lmax / 100;
      up_b = thresh[REG_BIG_UP] * bmax / 100;
      dn_b = thresh[REG_BIG_DOWN] * bmax / 100;
      if (tick_count != 16'hffff) tick_count++;
      first = core_freq(it, 0);
      fast = first;
      slow = 64'h7fffffffffffffff;
      sc = 0;
      for (c = 1; c < NCL; c++) begin
        if (core_mask[c]) begin
          r = core_freq(it, c);
          if (r <= slow) begin
            sc = c;
            slow = r;
          end else if (r > fast) fast = r;
        end
      end
      if (first < slow) slow = first;
      nl = online_count(0, NCL);
      if (slow > up_l) begin
        if (nl < NCL && tick_count >= thresh[REG_UP_WAIT]) begin
          for (c = 1; c < 8; c++)
            if (!core_mask[c]) begin
              push_command(c, ACT_ONLINE, n);
              break;
            end
          tick_count = 0;
        end
      end else if (sc != 0 && fast < dn_l) begin
        if (nl > thresh[REG_LITTLE_MIN] && tick_count >= thresh[REG_DOWN_WAIT]) begin
          if (core_mask[sc]) push_command(sc, ACT_OFFLINE, n);
          tick_count = 0;
        end
      end
      nl = online_count(0, NCL);
      nb = online_count(NCL, 8);
      if (nb == 0) begin
        // big cluster asleep while littles are saturated: hand over to a big core
        if (nl >= NCL) begin
          for (c = NCL; c < 8; c++)
            if (!core_mask[c]) begin
              push_command(c, ACT_ONLINE, n);
              break;
            end
          while (nl > 2) begin
            for (c = 1; c < NCL; c++) if (core_mask[c]) break;
            if (c >= NCL) break;
            push_command(c, ACT_OFFLINE, n);
            nl--;
          end
        end
      end else begin
        for (b0 = NCL; b0 < 8; b0++) if (core_mask[b0]) break;
        first = core_freq(it, b0);
        fast = first;
        slow = 64'h7fffffffffffffff;
        sc = NCL;
        for (c = NCL; c < 8; c++) begin
          if (core_mask[c]) begin
            r = core_freq(it, c);
            if (r <= slow) begin
              sc = c;
              slow = r;
            end else if (r > fast) fast = r;
          end
        end
        if (first < slow) slow = first;
        if (slow > up_b) begin
          if (nb < NCL && tick_count >= thresh[REG_UP_WAIT]) begin
            for (c = NCL; c < 8; c++)
              if (!core_mask[c]) begin
                push_command(c, ACT_ONLINE, n);
                break;
              end
            tick_count = 0;
          end
        end else if (fast < dn_b) begin
          // big cluster unplug waits three times longer
          if (nb > thresh[REG_BIG_MIN] && tick_count >= 3 * thresh[REG_DOWN_WAIT]) begin
            if (core_mask[sc]) push_command(sc, ACT_OFFLINE, n);
            tick_count = 0;
          end
        end
      end
    end
  endtask

  task automatic predict_item(input in_t it);
    int n;
    begin
      n = 0;
      if (it.opcode == OP_TICK) predict_tick(it, n);
      else if (it.opcode == OP_SCREEN_OFF) begin
        for (int c = 7; c >= 1; c--) if (core_mask[c]) push_command(c, ACT_OFFLINE, n);
      end else if (it.opcode == OP_SCREEN_ON) begin
        for (int c = 0; c < 8; c++) if (!core_mask[c]) push_command(c, ACT_ONLINE, n);
      end
      // nothing moved: a single no-change command
      if (n == 0) push_command(0, ACT_NONE, n);
      expected_cmds[expected_cmds.size() - 1].last_command = 1'b1;
    end
  endtask

  function automatic in_t rand_item(input int maxf);
    in_t it;
    int m;
    logic [223:0] raw;
    begin
      it = '0;
      m = $urandom_range(3, 0);
      // mostly ticks, occasional screen events and the unused opcode
      if (m < 2 || $urandom_range(3, 0) != 0) it.opcode = OP_TICK;
      else it.opcode = 2'($urandom_range(3, 0));
      it.little_max_freq = FREQ_W'($urandom_range(maxf, 1));
      it.big_max_freq = FREQ_W'($urandom_range(maxf, 1));
      it.freq_core0 = FREQ_W'($urandom_range(it.little_max_freq, 0));
      it.freq_core1 = FREQ_W'($urandom_range(it.little_max_freq, 0));
      it.freq_core2 = FREQ_W'($urandom_range(it.little_max_freq, 0));
      it.freq_core3 = FREQ_W'($urandom_range(it.little_max_freq, 0));
      it.freq_core4 = FREQ_W'($urandom_range(it.big_max_freq, 0));
      it.freq_core5 = FREQ_W'($urandom_range(it.big_max_freq, 0));
      it.freq_core6 = FREQ_W'($urandom_range(it.big_max_freq, 0));
      it.freq_core7 = FREQ_W'($urandom_range(it.big_max_freq, 0));
      if ($urandom_range(9, 0) == 0) begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it[FREQ_W*10-1:0] = raw[FREQ_W*10-1:0];
      end
      return it;
    end
  endfunction

  function automatic in_t flat_item(input logic [1:0] op, input logic [21:0] f,
                                    input logic [21:0] mx);
    in_t it;
    begin
      it.opcode = op;
      it.freq_core0 = f; it.freq_core1 = f; it.freq_core2 = f; it.freq_core3 = f;
      it.freq_core4 = f; it.freq_core5 = f; it.freq_core6 = f; it.freq_core7 = f;
      it.little_max_freq = mx;
      it.big_max_freq = mx;
      return it;
    end
  endfunction

  // write one register at a falling edge, predictor follows
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      @(negedge clk);
      cfg_we <= 1'b0;
      case (idx)
        REG_LITTLE_MIN, REG_BIG_MIN: thresh[idx] = val & 8'd7;
        REG_UP_WAIT, REG_DOWN_WAIT: thresh[idx] = val;
        default: thresh[idx] = val & 8'd127;
      endcase
    end
  endtask

  task automatic wait_drained();
    begin
      while (pending_items.size() != 0 || expected_cmds.size() != 0) @(posedge clk);
      repeat (20) @(posedge clk);
    end
  endtask

  task automatic load_setting(input logic [7:0] lu, input logic [7:0] ld, input logic [7:0] bu,
                              input logic [7:0] bd, input logic [7:0] lm, input logic [7:0] bm,
                              input logic [7:0] uw, input logic [7:0] dw);
    begin
      wait_drained();
      write_reg(REG_LITTLE_UP, lu);
      write_reg(REG_LITTLE_DOWN, ld);
      write_reg(REG_BIG_UP, bu);
      write_reg(REG_BIG_DOWN, bd);
      write_reg(REG_LITTLE_MIN, lm);
      write_reg(REG_BIG_MIN, bm);
      write_reg(REG_UP_WAIT, uw);
      write_reg(REG_DOWN_WAIT, dw);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // driver: presents pending items, inserts random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall_seen) begin
      // item was taken at the last rising edge
      if (in_gap == 0 && !quiet_phase && $urandom_range(7, 0) == 0) in_gap = $urandom_range(10, 1);
      if (in_gap > 0 || pending_items.size() == 0) begin
        in_valid <= 1'b0;
        if (in_gap > 0) in_gap--;
      end else begin
        in_item <= pending_items[0];
        in_valid <= 1'b1;
      end
    end else if (!in_valid) begin
      if (in_gap > 0) in_gap--;
      else if (pending_items.size() != 0) begin
        in_item <= pending_items[0];
        in_valid <= 1'b1;
      end
    end
  end

  // stall seen at the last rising edge, so the driver never races the sample
  always @(posedge clk) begin
    in_stall_seen <= in_stall;
    if (!rst && in_valid && !in_stall) begin
      predict_item(pending_items.pop_front());
    end
  end

  // receiver stall in bursts
  always @(negedge clk) begin
    if (rst || quiet_phase) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else if ($urandom_range(9, 0) == 0) begin
      out_hold = $urandom_range(10, 1) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: compare each accepted command with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        report($sformatf("unexpected command %h", out_item));
      end else begin
        want = expected_cmds.pop_front();
        if (out_item.core_index !== want.core_index)
          report($sformatf("core_index %0d want %0d", out_item.core_index, want.core_index));
        if (out_item.action !== want.action)
          report($sformatf("action %0d want %0d", out_item.action, want.action));
        if (out_item.last_command !== want.last_command)
          report($sformatf("last_command %0b want %0b", out_item.last_command,
                           want.last_command));
        if (out_item.online_mask !== want.online_mask)
          report($sformatf("online_mask %h want %h", out_item.online_mask, want.online_mask));
      end
    end
  end

  // watchdog: cycles with no traffic on either channel
  always @(posedge clk) begin
    if (rst || done || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("load_based_core_hotplug_policy_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    in_t it;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    idle_cycles = 0;
    quiet_phase = 1'b0;
    done = 1'b0;
    in_gap = 0;
    out_hold = 0;
    core_mask = 8'hff;
    tick_count = '0;
    thresh[0] = 60; thresh[1] = 30; thresh[2] = 90; thresh[3] = 60;
    thresh[4] = 1; thresh[5] = 0; thresh[6] = 1; thresh[7] = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: idle load sheds cores, screen events, extremes, unused opcode
    pending_items.push_back(flat_item(OP_TICK, 22'd0, 22'h3fffff));
    pending_items.push_back(flat_item(OP_TICK, 22'd0, 22'h3fffff));
    pending_items.push_back(flat_item(OP_TICK, 22'd10, 22'h3fffff));
    pending_items.push_back(flat_item(OP_SCREEN_OFF, 22'd0, 22'd0));
    pending_items.push_back(flat_item(OP_SCREEN_OFF, 22'd0, 22'd0));
    pending_items.push_back(flat_item(OP_TICK, 22'h3fffff, 22'h3fffff));
    pending_items.push_back(flat_item(OP_TICK, 22'h3fffff, 22'h3fffff));
    pending_items.push_back(flat_item(OP_TICK, 22'h3fffff, 22'h3fffff));
    pending_items.push_back(flat_item(OP_TICK, 22'h3fffff, 22'h3fffff));
    pending_items.push_back(flat_item(OP_TICK, 22'h3fffff, 22'h3fffff));
    pending_items.push_back(flat_item(OP_SCREEN_ON, 22'h3fffff, 22'd0));
    pending_items.push_back(flat_item(OP_SCREEN_ON, 22'd0, 22'd0));
    pending_items.push_back(flat_item(2'd3, 22'h2aaaaa, 22'h155555));
    pending_items.push_back(flat_item(OP_TICK, 22'h155555, 22'h2aaaaa));
    pending_items.push_back(flat_item(OP_TICK, 22'd0, 22'd0));

    // extremes: all zero thresholds and waits, then maxima
    load_setting(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    pending_items.push_back(flat_item(OP_SCREEN_OFF, 22'd0, 22'd0));
    repeat (4) pending_items.push_back(flat_item(OP_TICK, 22'd5, 22'd100));
    load_setting(8'd100, 8'd100, 8'd100, 8'd100, 8'd4, 8'd4, 8'd255, 8'd255);
    repeat (4) pending_items.push_back(flat_item(OP_TICK, 22'd5, 22'd100));
    pending_items.push_back(flat_item(OP_SCREEN_ON, 22'd0, 22'd0));

    // random phases, each under a random setting
    for (int ph = 0; ph < 6; ph++) begin
      load_setting(8'($urandom_range(100, 0)), 8'($urandom_range(100, 0)),
                   8'($urandom_range(100, 0)), 8'($urandom_range(100, 0)),
                   8'($urandom_range(4, 0)), 8'($urandom_range(4, 0)),
                   8'($urandom_range(3, 0)), 8'($urandom_range(2, 0)));
      if (ph == 5) quiet_phase = 1'b1;
      for (int k = 0; k < 35; k++) begin
        it = rand_item(ph[0] ? 4194303 : 2000);
        pending_items.push_back(it);
      end
    end
    load_setting(8'd60, 8'd30, 8'd90, 8'd60, 8'd1, 8'd0, 8'd1, 8'd1);
    repeat (10) pending_items.push_back(rand_item(4194303));

    wait_drained();
    done = 1'b1;
    if (error_count == 0) begin
      $display("load_based_core_hotplug_policy_tb OK");
    end else begin
      $display("load_based_core_hotplug_policy_tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+sv
sv/lbhp_pkg.sv
sv/lbhp_front.sv
sv/lbhp_back.sv
sv/load_based_core_hotplug_policy.sv
sv/lbhp_checker.sv
sim/load_based_core_hotplug_policy_tb.sv
